// ===== rtl/core/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths and types of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 4;
  localparam int REG_N     = 8;
  localparam int SUM_W     = 66;
  localparam int MAG_W     = 65;
  localparam int Q_W       = 32;
  localparam int DIV_LAT   = Q_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]          cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [Q_W-1:0]            quot_t;

endpackage

// ===== rtl/core/hpt_ifs.sv =====
// ----------------------------------------------------------------------------
// hpt_ifs
// Point and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpt_point_if;
  logic           valid;
  logic           ready;
  hpt_pkg::coord_t in_x;
  hpt_pkg::coord_t in_y;
  hpt_pkg::coord_t in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface hpt_result_if;
  logic           valid;
  logic           ready;
  hpt_pkg::coord_t out_x;
  hpt_pkg::coord_t out_y;
  hpt_pkg::coord_t out_z;
  logic           w_zero;
  logic           saturated;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output w_zero, output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input w_zero, input saturated, output ready);
endinterface

// ===== rtl/core/hpt_divider.sv =====
// ----------------------------------------------------------------------------
// hpt_divider
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage, with an overflow flag when the quotient needs more than 32 bits.
// ----------------------------------------------------------------------------
module hpt_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          en,
  input  hpt_pkg::mag_t num,
  input  hpt_pkg::mag_t den,
  input  logic          neg_in,
  output hpt_pkg::quot_t q,
  output logic          ovf,
  output logic          neg_out
);

  localparam int QW = hpt_pkg::Q_W;
  localparam int RW = hpt_pkg::MAG_W + QW;

  logic [RW-1:0]    rem_r [0:QW];
  hpt_pkg::mag_t    den_r [0:QW];
  hpt_pkg::quot_t   q_r   [0:QW];
  logic             ovf_r [0:QW];
  logic             neg_r [0:QW];

  logic [RW-1:0] num_sh;
  assign num_sh = RW'(num) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_sh;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= num_sh >= {den, QW'(0)};
      neg_r[0] <= neg_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(den_r[s]) << B;
    assign ge    = rem_r[s] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? rem_r[s] - trial : rem_r[s];
        den_r[s+1] <= den_r[s];
        q_r[s+1]   <= q_r[s] | (QW'(ge) << B);
        ovf_r[s+1] <= ovf_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  assign q       = q_r[QW];
  assign ovf     = ovf_r[QW];
  assign neg_out = neg_r[QW];

endmodule

// ===== rtl/core/homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix times (x, y, z, 1), then X/W, Y/W, Z/W saturated to fixed point.
// ----------------------------------------------------------------------------
//   channel | dir | transaction
//   in_ch   | in  | point in_x, in_y, in_z
//   out_ch  | out | out_x, out_y, out_z, w_zero, saturated
//   cfg_*   | in  | matrix register write, index 0..7, others ignored
//
// One transaction per cycle unless out stalls. Stages: multiply, sum, magnitude,
// 33 divider stages (input, then one quotient bit per stage), output register.
// Synchronous active-low reset clears valids and loads the identity matrix.
// Out stall freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hpt_point_if.sink             in_ch,
  hpt_result_if.source          out_ch,
  input  logic                  cfg_we,
  input  hpt_pkg::cfg_idx_t     cfg_index,
  input  hpt_pkg::cfg_word_t    cfg_data
);

  localparam int CW  = hpt_pkg::COORD_W;
  localparam int QW  = hpt_pkg::Q_W;
  localparam int DL  = hpt_pkg::DIV_LAT;
  localparam hpt_pkg::cfg_word_t ONE_LO = hpt_pkg::CFG_W'(1) << FRAC_BITS;
  localparam hpt_pkg::cfg_word_t ONE_HI = ONE_LO << CW;

  hpt_pkg::cfg_word_t mat_r [0:hpt_pkg::REG_N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= ONE_HI;
      mat_r[1] <= '0;
      mat_r[2] <= ONE_LO;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= ONE_HI;
      mat_r[6] <= '0;
      mat_r[7] <= ONE_LO;
    end else if (cfg_we && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::REG_N))) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: products
  logic            v1_r;
  logic signed [2*CW-1:0] prod_r [0:3][0:2];
  hpt_pkg::coord_t m3_r [0:3];
  hpt_pkg::coord_t pt [0:2];
  assign pt[0] = in_ch.in_x;
  assign pt[1] = in_ch.in_y;
  assign pt[2] = in_ch.in_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= $signed(mat_r[2*r][63:32]) * pt[0];
        prod_r[r][1] <= $signed(mat_r[2*r][31:0])  * pt[1];
        prod_r[r][2] <= $signed(mat_r[2*r+1][63:32]) * pt[2];
        m3_r[r]      <= $signed(mat_r[2*r+1][31:0]);
      end
    end
  end

  // stage 2: exact sums
  logic         v2_r;
  hpt_pkg::sum_t sum_r [0:3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        sum_r[r] <= hpt_pkg::SUM_W'(prod_r[r][0]) + hpt_pkg::SUM_W'(prod_r[r][1])
                  + hpt_pkg::SUM_W'(prod_r[r][2])
                  + (hpt_pkg::SUM_W'(m3_r[r]) <<< FRAC_BITS);
      end
    end
  end

  // stage 3: magnitudes and signs
  logic          v3_r;
  hpt_pkg::mag_t mag_r [0:3];
  logic          sgn_r [0:3];
  logic          wz3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        mag_r[r] <= sum_r[r][hpt_pkg::SUM_W-1] ? hpt_pkg::MAG_W'(-sum_r[r])
                                              : hpt_pkg::MAG_W'(sum_r[r]);
        sgn_r[r] <= sum_r[r][hpt_pkg::SUM_W-1];
      end
      wz3_r <= (sum_r[3] == '0);
    end
  end

  // divider lanes
  hpt_pkg::quot_t q    [0:2];
  logic           ovf  [0:2];
  logic           qneg [0:2];
  for (genvar l = 0; l < 3; l++) begin : g_lane
    hpt_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk     (clk),
      .en      (adv),
      .num     (mag_r[l]),
      .den     (mag_r[3]),
      .neg_in  (sgn_r[l] ^ sgn_r[3]),
      .q       (q[l]),
      .ovf     (ovf[l]),
      .neg_out (qneg[l])
    );
  end

  logic [DL-1:0] vd_r;
  logic [DL-1:0] wzd_r;
  always_ff @(posedge clk) begin
    if (adv) wzd_r <= {wzd_r[DL-2:0], wz3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vd_r <= '0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vd_r <= {vd_r[DL-2:0], v3_r};
    end
  end

  // final stage: sign, saturation
  hpt_pkg::coord_t res_nxt [0:2];
  logic [2:0]      sat_nxt;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sat_nxt[l] = ovf[l] || (qneg[l] ? (q[l] > {1'b1, (QW-1)'(0)}) : q[l][QW-1]);
      if (sat_nxt[l]) res_nxt[l] = qneg[l] ? {1'b1, (CW-1)'(0)} : {1'b0, {(CW-1){1'b1}}};
      else            res_nxt[l] = qneg[l] ? -$signed(q[l]) : $signed(q[l]);
    end
  end

  hpt_pkg::coord_t ox_r, oy_r, oz_r;
  logic            wz_r, sat_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      wz_r  <= wzd_r[DL-1];
      sat_r <= !wzd_r[DL-1] && (|sat_nxt);
      ox_r  <= wzd_r[DL-1] ? '0 : res_nxt[0];
      oy_r  <= wzd_r[DL-1] ? '0 : res_nxt[1];
      oz_r  <= wzd_r[DL-1] ? '0 : res_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)   out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vd_r[DL-1];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = ox_r;
  assign out_ch.out_y     = oy_r;
  assign out_ch.out_z     = oz_r;
  assign out_ch.w_zero    = wz_r;
  assign out_ch.saturated = sat_r;

`ifndef SYNTHESIS
  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.w_zero |->
      out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0 && !out_ch.saturated)
    else $error("w_zero result not cleared");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted transaction missing in stage 1");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vd_r) && $stable(v3_r))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for homogeneous_point_transform: loads 4x4 matrices
// through the cfg port, streams points with bursty valid and a stalling ready,
// and checks results against typed values or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module testbench;

  typedef hpt_pkg::coord_t    coord_t;
  typedef hpt_pkg::cfg_idx_t  cfg_idx_t;
  typedef hpt_pkg::cfg_word_t cfg_word_t;

  localparam int REG_N    = hpt_pkg::REG_N;
  localparam int FRAC     = 16;
  localparam int DRAIN    = 45;
  localparam int HOLD_LEN = 300;

  typedef enum logic [1:0] {M_IDENT, M_NULLW, M_HUGE} mat_sel_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w_zero;
    logic   sat;
  } point_res_t;

  typedef struct {
    mat_sel_e   sel;
    coord_t     x, y, z;
    bit         typed;
    point_res_t want;
  } stim_row_t;

  localparam coord_t CMAX = 32'sh7FFFFFFF;
  localparam coord_t CMIN = 32'sh80000000;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_word_t cfg_data;

  hpt_point_if  in_if ();
  hpt_result_if out_if ();

  homogeneous_point_transform #(.FRAC_BITS(FRAC)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfg_word_t  matrix [REG_N];
  point_res_t pending_results [$];
  int         errors;
  int         points_sent;
  int         results_seen;
  int         wzero_seen;
  int         sat_seen;
  int         burst_left;
  bit         hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1_000_000);
    $display("testbench: errors");
    $finish;
  end

  function automatic point_res_t project_point(coord_t px, coord_t py, coord_t pz);
    logic signed [127:0] acc [4];
    logic signed [127:0] coef, pv;
    logic [127:0] wmag, amag, q;
    logic [31:0]  lim, val [3];
    logic         wneg, aneg, neg;
    point_res_t   r;
    coord_t       c;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      acc[i] = '0;
      for (int k = 0; k < 4; k++) begin
        c = (k % 2) ? matrix[2*i + k/2][31:0] : matrix[2*i + k/2][63:32];
        coef = c;
        case (k)
          0: pv = px;
          1: pv = py;
          2: pv = pz;
          default: pv = 128'sd1 <<< FRAC;
        endcase
        acc[i] = acc[i] + coef * pv;
      end
    end
    if (acc[3] == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    wneg = acc[3][127];
    wmag = wneg ? -acc[3] : acc[3];
    for (int i = 0; i < 3; i++) begin
      aneg = acc[i][127];
      amag = aneg ? -acc[i] : acc[i];
      neg  = aneg ^ wneg;
      lim  = neg ? 32'h80000000 : 32'h7FFFFFFF;
      q    = (amag << FRAC) / wmag;
      if (q > {96'd0, lim}) begin
        r.sat  = 1'b1;
        val[i] = lim;
      end else begin
        val[i] = neg ? -q[31:0] : q[31:0];
      end
    end
    r.x = val[0];
    r.y = val[1];
    r.z = val[2];
    return r;
  endfunction

  task automatic write_matrix(cfg_word_t m [REG_N]);
    for (int i = 0; i < REG_N; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= m[i];
      matrix[i] = m[i];
      @(negedge clk);
    end
    cfg_index <= cfg_idx_t'($urandom_range(REG_N, 15));
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z);
    int gap;
    in_if.valid <= 1'b1;
    in_if.in_x  <= x;
    in_if.in_y  <= y;
    in_if.in_z  <= z;
    do @(posedge clk); while (!in_if.ready);
    pending_results.insert(pending_results.size(), project_point(x, y, z));
    points_sent++;
    burst_left--;
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  function automatic coord_t rand_coord(int mag_bits);
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3, 4, 5: return coord_t'($urandom);
      default: return coord_t'($signed($urandom) >>> (31 - mag_bits));
    endcase
  endfunction

  function automatic cfg_word_t pack_row(coord_t a, coord_t b);
    return {a, b};
  endfunction

  task automatic random_matrix(int mode, output cfg_word_t m [REG_N]);
    for (int r = 0; r < 3; r++) begin
      m[2*r]   = pack_row(rand_coord(18), rand_coord(18));
      m[2*r+1] = pack_row(rand_coord(18), rand_coord(22));
    end
    case (mode)
      0: begin
        m[6] = {$urandom, $urandom};
        m[7] = {$urandom, $urandom};
      end
      1: begin
        m[6] = '0;
        m[7] = pack_row('0, coord_t'(1 << FRAC));
      end
      default: begin
        m[6] = '0;
        m[7] = pack_row(coord_t'(1 << FRAC), '0);
      end
    endcase
  endtask

  stim_row_t directed [$];

  task automatic add_row(stim_row_t row);
    directed.insert(directed.size(), row);
  endtask

  task automatic build_directed();
    point_res_t w0, id;
    w0 = '0;
    w0.w_zero = 1'b1;
    id = '0;
    add_row('{M_IDENT, '0, '0, '0, 1, id});
    id = '{CMAX, CMAX, CMAX, 1'b0, 1'b0};
    add_row('{M_IDENT, CMAX, CMAX, CMAX, 1, id});
    id = '{CMIN, CMIN, CMIN, 1'b0, 1'b0};
    add_row('{M_IDENT, CMIN, CMIN, CMIN, 1, id});
    id = '{CMAX, CMIN, 32'sh00010000, 1'b0, 1'b0};
    add_row('{M_IDENT, CMAX, CMIN, 32'sh00010000, 1, id});
    id = '{32'sh00000001, 32'shFFFFFFFF, 32'sh55555555, 1'b0, 1'b0};
    add_row('{M_IDENT, 32'sh1, -32'sh1, 32'sh55555555, 1, id});
    add_row('{M_NULLW, '0, '0, '0, 1, w0});
    add_row('{M_NULLW, CMAX, CMIN, CMAX, 1, w0});
    add_row('{M_NULLW, CMIN, CMAX, 32'sh12345678, 1, w0});
    id = '{CMAX, CMAX, CMAX, 1'b0, 1'b1};
    add_row('{M_HUGE, CMAX, CMAX, CMAX, 1, id});
    id = '{CMIN, CMIN, CMIN, 1'b0, 1'b1};
    add_row('{M_HUGE, CMIN, CMIN, CMIN, 1, id});
    add_row('{M_HUGE, '0, '0, '0, 0, id});
    add_row('{M_HUGE, -32'sh1, 32'sh1, '0, 0, id});
    add_row('{M_HUGE, CMIN, '0, '0, 0, id});
  endtask

  task automatic select_matrix(mat_sel_e sel);
    cfg_word_t m [REG_N];
    case (sel)
      M_IDENT: begin
        for (int i = 0; i < REG_N; i++) m[i] = '0;
        m[0] = pack_row(coord_t'(1 << FRAC), '0);
        m[2] = pack_row('0, coord_t'(1 << FRAC));
        m[5] = pack_row(coord_t'(1 << FRAC), '0);
        m[7] = pack_row('0, coord_t'(1 << FRAC));
      end
      M_NULLW: for (int i = 0; i < REG_N; i++) m[i] = {$urandom, $urandom} & {64{i < 6}};
      default: begin
        for (int i = 0; i < 6; i++) m[i] = {CMAX, CMAX};
        m[6] = '0;
        m[7] = pack_row('0, 32'sd1);
      end
    endcase
    write_matrix(m);
  endtask

  // receiver: own stall pattern plus one long hold-off on request
  initial begin
    int cnt;
    out_if.ready = 1'b0;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      cnt++;
      if (cnt % 200 < 60) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    point_res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_x, out_if.out_y, out_if.out_z, out_if.w_zero, out_if.saturated};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction x=%h y=%h z=%h wz=%b sat=%b", $time,
                 got.x, got.y, got.z, got.w_zero, got.sat);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (got.w_zero) wzero_seen++;
        if (got.sat) sat_seen++;
        if (got !== want) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b sat=%b", $time,
                   want.x, want.y, want.z, want.w_zero, want.sat);
          $display("%0t:          actual   x=%h y=%h z=%h wz=%b sat=%b", $time,
                   got.x, got.y, got.z, got.w_zero, got.sat);
          errors++;
        end
      end
    end
  end

  initial begin
    cfg_word_t m [REG_N];
    mat_sel_e  cur;
    int        mode;
    errors       = 0;
    points_sent  = 0;
    results_seen = 0;
    wzero_seen   = 0;
    sat_seen     = 0;
    burst_left   = 4;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.in_x   = '0;
    in_if.in_y   = '0;
    in_if.in_z   = '0;
    select_matrix_shadow();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    build_directed();
    cur = M_IDENT;
    foreach (directed[i]) begin
      if (directed[i].sel != cur) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
        wait_idle();
        cur = directed[i].sel;
        select_matrix(cur);
      end
      if (directed[i].typed) begin
        send_point(directed[i].x, directed[i].y, directed[i].z);
        pending_results[$] = directed[i].want;
      end else begin
        send_point(directed[i].x, directed[i].y, directed[i].z);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
      wait_idle();
      mode = ph % 3;
      random_matrix(mode, m);
      write_matrix(m);
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 85; n++) begin
        if (mode == 2 && $urandom_range(0, 9) == 0)
          send_point(rand_coord(20), rand_coord(20), '0);
        else
          send_point(rand_coord(20), rand_coord(20), rand_coord(20));
      end
    end
    in_if.valid <= 1'b0;
    @(negedge clk);
    wait_idle();

    $display("sent %0d points, %0d results checked (%0d w zero, %0d saturated)",
             points_sent, results_seen, wzero_seen, sat_seen);
    $display("matrices: identity, zero w row, saturating, and six random sets");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // predictor copy of the reset matrix
  task automatic select_matrix_shadow();
    for (int i = 0; i < REG_N; i++) matrix[i] = '0;
    matrix[0] = pack_row(coord_t'(1 << FRAC), '0);
    matrix[2] = pack_row('0, coord_t'(1 << FRAC));
    matrix[5] = pack_row(coord_t'(1 << FRAC), '0);
    matrix[7] = pack_row('0, coord_t'(1 << FRAC));
  endtask

endmodule
